>>> sv/nrte_pkg.sv
// ----------------------------------------------------------------------------
// nrte_pkg
// Shared types, character codes and helper functions of the RMC time
// extractor.
// ----------------------------------------------------------------------------
package nrte_pkg;

    localparam int BYTE_W    = 8;
    localparam int HOUR_W    = 5;
    localparam int TIME_W    = 7;
    localparam int DIGIT_W   = 4;
    localparam int N_DIGITS  = 6;
    localparam int HDR_LEN   = 5;
    localparam int APB_AW    = 2;
    localparam int APB_DW    = 32;

    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;

    localparam logic [HOUR_W-1:0] HOUR_OFFSET_RST  = 5'd8;
    localparam logic [APB_AW-1:0] ADDR_HOUR_OFFSET = 2'd0;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY,
        PH_CK1,
        PH_CK2
    } t_phase;

    typedef enum logic [1:0] {
        VD_ACCEPTED   = 2'd0,
        VD_NOT_ACTIVE = 2'd1,
        VD_MISMATCH   = 2'd2
    } t_verdict;

    typedef struct packed {
        logic              valid;
        t_verdict          verdict;
        logic [HOUR_W-1:0] local_hour;
        logic [TIME_W-1:0] minute_value;
        logic [TIME_W-1:0] second_value;
    } t_result;

    // Expected header character after the dollar sign.
    function automatic logic [BYTE_W-1:0] hdr_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h50; // P
            3'd2:    c = 8'h52; // R
            3'd3:    c = 8'h4D; // M
            3'd4:    c = 8'h43; // C
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    // Returns {ok, nibble}; ok is low for a non-hex character.
    function automatic logic [DIGIT_W:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [DIGIT_W:0] r;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end else begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] times_ten(input logic [DIGIT_W-1:0] d);
        return {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
    endfunction

    // Restoring reduction; the input never exceeds 196.
    function automatic logic [HOUR_W-1:0] mod24(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] v;
        v = x;
        if (v >= 8'd192) v = v - 8'd192;
        if (v >= 8'd96)  v = v - 8'd96;
        if (v >= 8'd48)  v = v - 8'd48;
        if (v >= 8'd24)  v = v - 8'd24;
        return v[HOUR_W-1:0];
    endfunction

endpackage

>>> sv/nrte_apb_regs.sv
// ----------------------------------------------------------------------------
// nrte_apb_regs
// APB register file holding the hour offset.
// ----------------------------------------------------------------------------
module nrte_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nrte_pkg::APB_AW-1:0] paddr,
    input  logic [nrte_pkg::APB_DW-1:0] pwdata,
    output logic [nrte_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [nrte_pkg::HOUR_W-1:0] o_hour_offset
);
    import nrte_pkg::*;

    logic [HOUR_W-1:0] r_hour_offset;
    logic              wr_hit;

    assign wr_hit = psel && penable && pwrite && (paddr == ADDR_HOUR_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hour_offset <= HOUR_OFFSET_RST;
        end else if (wr_hit) begin
            r_hour_offset <= pwdata[HOUR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_HOUR_OFFSET) begin
            prdata = {{(APB_DW-HOUR_W){1'b0}}, r_hour_offset};
        end
    end

    assign pready        = 1'b1;
    assign o_hour_offset = r_hour_offset;

endmodule

>>> sv/nrte_parser.sv
// ----------------------------------------------------------------------------
// nrte_parser
// Sentence state machine: header match, parity, field tracking, checksum.
// ----------------------------------------------------------------------------
module nrte_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [nrte_pkg::BYTE_W-1:0] i_byte,
    input  logic [nrte_pkg::HOUR_W-1:0] i_hour_offset,
    output nrte_pkg::t_result           o_result
);
    import nrte_pkg::*;

    t_phase                    r_phase,  n_phase;
    logic [2:0]                r_hdr_pos, n_hdr_pos;
    logic [3:0]                r_field,  n_field;
    logic [2:0]                r_char,   n_char;
    logic [BYTE_W-1:0]         r_parity, n_parity;
    logic [DIGIT_W-1:0]        r_digits [N_DIGITS];
    logic [DIGIT_W-1:0]        n_digits [N_DIGITS];
    logic                      r_active, n_active;
    logic [DIGIT_W-1:0]        r_ck_hi,  n_ck_hi;

    logic [DIGIT_W:0]          hex;
    logic [BYTE_W-1:0]         check;
    logic [BYTE_W-1:0]         hour_sum;

    assign hex      = hex_decode(i_byte);
    assign check    = {r_ck_hi, hex[DIGIT_W-1:0]};
    assign hour_sum = times_ten(r_digits[0]) + {4'b0000, r_digits[1]}
                    + {3'b000, i_hour_offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_hdr_pos <= '0;
            r_field   <= '0;
            r_char    <= '0;
            r_parity  <= '0;
            r_active  <= 1'b0;
            r_ck_hi   <= '0;
            for (int i = 0; i < N_DIGITS; i++) r_digits[i] <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_pos <= n_hdr_pos;
            r_field   <= n_field;
            r_char    <= n_char;
            r_parity  <= n_parity;
            r_active  <= n_active;
            r_ck_hi   <= n_ck_hi;
            r_digits  <= n_digits;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_hdr_pos = r_hdr_pos;
        n_field   = r_field;
        n_char    = r_char;
        n_parity  = r_parity;
        n_active  = r_active;
        n_ck_hi   = r_ck_hi;
        n_digits  = r_digits;

        o_result              = '0;
        o_result.verdict      = VD_ACCEPTED;
        o_result.local_hour   = mod24(hour_sum);
        o_result.minute_value = TIME_W'(times_ten(r_digits[2]) + {4'b0000, r_digits[3]});
        o_result.second_value = TIME_W'(times_ten(r_digits[4]) + {4'b0000, r_digits[5]});

        if (i_step) begin
            if (i_byte == CH_DOLLAR) begin
                // restart the sentence
                n_phase   = PH_HEADER;
                n_hdr_pos = '0;
                n_field   = '0;
                n_char    = '0;
                n_parity  = '0;
                n_active  = 1'b0;
                for (int i = 0; i < N_DIGITS; i++) n_digits[i] = '0;
            end else if (is_space(i_byte)) begin
                n_phase = PH_IDLE;
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_hdr_pos < 3'(HDR_LEN) && i_byte == hdr_char(r_hdr_pos)) begin
                            n_parity  = r_parity ^ i_byte;
                            n_hdr_pos = r_hdr_pos + 3'd1;
                            if (r_hdr_pos == 3'(HDR_LEN - 1)) n_phase = PH_BODY;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_BODY: begin
                        if (i_byte == CH_STAR) begin
                            n_phase = PH_CK1;
                        end else begin
                            n_parity = r_parity ^ i_byte;
                            if (i_byte == CH_COMMA) begin
                                if (r_field != 4'hF) n_field = r_field + 4'd1;
                                n_char = '0;
                            end else begin
                                if (r_field == 4'd1 && r_char < 3'(N_DIGITS)) begin
                                    n_digits[r_char] = DIGIT_W'(i_byte - CH_ZERO);
                                end
                                if (r_field == 4'd2 && r_char == 3'd0) begin
                                    n_active = (i_byte == CH_UPPER_A);
                                end
                                if (r_char != 3'd7) n_char = r_char + 3'd1;
                            end
                        end
                    end
                    PH_CK1: begin
                        if (hex[DIGIT_W]) begin
                            n_ck_hi = hex[DIGIT_W-1:0];
                            n_phase = PH_CK2;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_CK2: begin
                        n_phase = PH_IDLE;
                        if (hex[DIGIT_W]) begin
                            o_result.valid = 1'b1;
                            if (!r_active) begin
                                o_result.verdict = VD_NOT_ACTIVE;
                            end else if (check != r_parity) begin
                                o_result.verdict = VD_MISMATCH;
                            end else begin
                                o_result.verdict = VD_ACCEPTED;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

endmodule

>>> sv/nmea_rmc_time_extractor_unit.sv
// ----------------------------------------------------------------------------
// nmea_rmc_time_extractor_unit
// Parses RMC sentences byte by byte and reports local time with a verdict.
// ----------------------------------------------------------------------------
// Path: a word passes the input register, then the result register.
// Throughput: 1 word per cycle unless a blocked result stalls the input;
//   the parser state loop updates once a cycle.
// Reset: synchronous, active low; parser returns to idle, output empties,
//   hour offset returns to 8.
module nmea_rmc_time_extractor_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input word channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [nrte_pkg::BYTE_W-1:0] i_text_byte,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [1:0]                  o_verdict,
    output logic [nrte_pkg::HOUR_W-1:0] o_local_hour,
    output logic [nrte_pkg::TIME_W-1:0] o_minute_value,
    output logic [nrte_pkg::TIME_W-1:0] o_second_value,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nrte_pkg::APB_AW-1:0] paddr,
    input  logic [nrte_pkg::APB_DW-1:0] pwdata,
    output logic [nrte_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import nrte_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           result;
    logic              advance;
    logic              in_take;
    logic [HOUR_W-1:0] hour_offset;

    // The pipeline moves whenever the result register is empty or being read.
    assign advance    = !r_out_valid || !i_out_stall;
    // Hold the upstream side only while a word waits behind a blocked result.
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register: capture each word, drop it once the parser has used it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_text_byte;
        end
    end

    nrte_apb_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_hour_offset (hour_offset)
    );

    // Parser consumes the registered word only when the result side can move,
    // so a result it produces always finds room.
    nrte_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (r_in_valid && advance),
        .i_byte        (r_in_byte),
        .i_hour_offset (hour_offset),
        .o_result      (result)
    );

    // Result register: load a fresh result or empty once the old one is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && result.valid) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_out.verdict;
    assign o_local_hour   = r_out.local_hour;
    assign o_minute_value = r_out.minute_value;
    assign o_second_value = r_out.second_value;

endmodule

>>> sv/nrte_checker.sv
// ----------------------------------------------------------------------------
// nrte_checker
// Port-level checks of the RMC time extractor, bound to the top level.
// ----------------------------------------------------------------------------
module nrte_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [1:0]                  o_verdict,
    input logic [nrte_pkg::HOUR_W-1:0] o_local_hour,
    input logic [nrte_pkg::TIME_W-1:0] o_minute_value,
    input logic [nrte_pkg::TIME_W-1:0] o_second_value
);
    import nrte_pkg::*;

    // A blocked result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verdict)
        && $stable(o_local_hour) && $stable(o_minute_value) && $stable(o_second_value))
        else $error("result changed while stalled");

    // Upstream is held back only by a blocked result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_local_hour < 5'd24)
        else $error("local hour out of range");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_verdict != 2'd3)
        else $error("undefined verdict code");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind nmea_rmc_time_extractor_unit nrte_checker u_nrte_checker (.*);
